@@ src/srbd_pkg.sv @@
// Shared types and constants for the speed ramp with braking distance block.
// Used by srbd_mul, srbd_div and the top level; depends on nothing.
package srbd_pkg;

    localparam int unsigned SPEED_W = 24;
    localparam int unsigned RATE_W  = 16;
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned BDIST_W = 40;

    // serial multiplier: multiplicand up to 25 bits, multiplier up to 24 bits
    localparam int unsigned MCAND_W = SPEED_W + 1;
    localparam int unsigned MPLR_W  = SPEED_W;
    localparam int unsigned PROD_W  = MCAND_W + MPLR_W;
    localparam int unsigned CNT_W   = 5;
    localparam logic [CNT_W-1:0] STEPS_TIME  = 5'd16;
    localparam logic [CNT_W-1:0] STEPS_SPEED = 5'd24;

    // serial divider: (v*v >> 1) / brake_rate
    localparam int unsigned DVD_W  = 2 * SPEED_W - 1;
    localparam int unsigned DVS_W  = RATE_W;
    localparam int unsigned DCNT_W = 6;
    localparam logic [DCNT_W-1:0] DIV_STEPS = 6'd47;

    localparam logic [1:0] OP_ACCEL = 2'd0;
    localparam logic [1:0] OP_DECEL = 2'd1;
    localparam logic [1:0] OP_ESTOP = 2'd2;

    localparam logic [1:0] CFG_LIMIT = 2'd0;
    localparam logic [1:0] CFG_ACCEL = 2'd1;
    localparam logic [1:0] CFG_BRAKE = 2'd2;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_SPEEDUP  = 2'd1,
        MODE_MAINTAIN = 2'd2,
        MODE_BRAKING  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_DELTA_W,
        S_UPDATE,
        S_DIST,
        S_DIST_W,
        S_SQR,
        S_SQR_W,
        S_DIV,
        S_DIV_W,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic done;
    } t_unit_sts;

endpackage

@@ src/srbd_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// After N steps the product sits at o_prod >> (24 - N). Uses srbd_pkg.
module srbd_mul
    import srbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_unit_ctl          i_ctl,
    input  logic [MCAND_W-1:0] i_mcand,
    input  logic [MPLR_W-1:0]  i_mplier,
    input  logic [CNT_W-1:0]   i_steps,
    output t_unit_sts          o_sts,
    output logic [PROD_W-1:0]  o_prod
);

    logic [PROD_W-1:0]  r_p;
    logic [MCAND_W-1:0] r_mcand;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MCAND_W:0]   n_hi;

    always_comb begin
        n_hi = {1'b0, r_p[PROD_W-1:MPLR_W]} + (r_p[0] ? {1'b0, r_mcand} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_p     <= {{MCAND_W{1'b0}}, i_mplier};
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_p <= {n_hi, r_p[MPLR_W-1:1]};
        end
    end

    assign o_sts.done = r_done;
    assign o_prod     = r_p;

endmodule

@@ src/srbd_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle, MSB first.
// Divides a 47-bit dividend by a 16-bit nonzero divisor. Uses srbd_pkg.
module srbd_div
    import srbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_unit_ctl        i_ctl,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_unit_sts        o_sts,
    output logic [DVD_W-1:0] o_quot
);

    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    n_trial;
    logic              n_fit;

    always_comb begin
        n_trial = {r_rem, r_q[DVD_W-1]};
        n_fit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DCNT_W'(1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DVD_W-2:0], n_fit};
            if (n_fit) begin
                r_rem <= DVS_W'(n_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= n_trial[DVS_W-1:0];
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

@@ src/speed_ramp_with_braking_distance.sv @@
// Speed ramp with braking distance: speed and motion state update per step.
// Top level; instantiates srbd_mul and srbd_div, uses srbd_pkg.
//
// Channels:
//   config - i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data. Always ready;
//            index 0 speed limit, 1 accel rate, 2 brake rate, 3 ignored.
//   input  - i_in_valid/o_in_ready, i_opcode, i_time_step.
//   output - o_out_valid/i_out_ready, o_distance, o_new_speed,
//            o_motion_state, o_braking_distance.
// One request in gives one request out. Requests are processed one at a time
// on a shared bit-serial multiplier and a bit-serial divider. Accelerate or
// decelerate also forms the speed delta product and, unless decelerate ends
// at zero speed, the distance product; every request forms the squared-speed
// product, and with brake rate zero the division is skipped.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls, a finished request holds until the
// output register frees. Reset clears speed, state and configuration to zero.
module speed_ramp_with_braking_distance
    import srbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [SPEED_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [RATE_W-1:0]    i_time_step,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DIST_W-1:0]    o_distance,
    output logic [SPEED_W-1:0]   o_new_speed,
    output logic [1:0]           o_motion_state,
    output logic [BDIST_W-1:0]   o_braking_distance
);

    t_state r_state, n_state;

    logic [SPEED_W-1:0] r_limit;
    logic [RATE_W-1:0]  r_accel;
    logic [RATE_W-1:0]  r_brake;
    logic [SPEED_W-1:0] r_speed;
    t_mode              r_mode;

    logic [1:0]         r_op;
    logic [RATE_W-1:0]  r_t;
    logic [MCAND_W-1:0] r_sum;
    logic               r_need_dist;
    logic [DIST_W-1:0]  r_dist;
    logic [BDIST_W-1:0] r_bdist;

    logic               r_out_valid;
    logic [DIST_W-1:0]  r_out_dist;
    logic [SPEED_W-1:0] r_out_speed;
    t_mode              r_out_mode;
    logic [BDIST_W-1:0] r_out_bdist;

    t_unit_ctl          mul_ctl, div_ctl;
    t_unit_sts          mul_sts, div_sts;
    logic [MCAND_W-1:0] mul_mcand;
    logic [MPLR_W-1:0]  mul_mplier;
    logic [CNT_W-1:0]   mul_steps;
    logic [PROD_W-1:0]  mul_prod;
    logic [DVD_W-1:0]   div_quot;

    logic [SPEED_W-1:0] n_delta;
    logic [MCAND_W-1:0] n_acc_sum;
    logic [SPEED_W-1:0] n_acc_v;
    logic [SPEED_W-1:0] n_dec_v;
    logic [SPEED_W-1:0] n_speed;
    t_mode              n_mode;
    logic               n_need_dist;
    logic               out_free;

    srbd_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mul_ctl),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .i_steps  (mul_steps),
        .o_sts    (mul_sts),
        .o_prod   (mul_prod)
    );

    srbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (mul_prod[2*SPEED_W-1:1]),
        .i_divisor  (r_brake),
        .o_sts      (div_sts),
        .o_quot     (div_quot)
    );

    assign out_free = !r_out_valid || i_out_ready;

    // speed update from the delta product (16 steps: product at [48:8])
    always_comb begin
        n_delta   = mul_prod[39:16];
        n_acc_sum = {1'b0, r_speed} + {1'b0, n_delta};
        n_acc_v   = n_acc_sum[SPEED_W] ? '1 : n_acc_sum[SPEED_W-1:0];
        if ((r_limit != '0) && (n_acc_v > r_limit)) begin
            n_acc_v = r_limit;
        end
        n_dec_v = (r_speed > n_delta) ? (r_speed - n_delta) : '0;
        case (r_op)
            OP_ACCEL: begin
                n_speed     = n_acc_v;
                n_mode      = (n_acc_v == r_limit) ? MODE_MAINTAIN : MODE_SPEEDUP;
                n_need_dist = 1'b1;
            end
            OP_DECEL: begin
                n_speed     = n_dec_v;
                n_mode      = (n_dec_v == '0) ? MODE_STOPPED : MODE_BRAKING;
                n_need_dist = (n_dec_v != '0);
            end
            OP_ESTOP: begin
                n_speed     = '0;
                n_mode      = MODE_STOPPED;
                n_need_dist = 1'b0;
            end
            default: begin
                n_speed     = r_speed;
                n_mode      = r_mode;
                n_need_dist = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if ((i_opcode == OP_ACCEL) || (i_opcode == OP_DECEL)) begin
                        n_state = S_DELTA;
                    end else begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_DELTA:   n_state = S_DELTA_W;
            S_DELTA_W: if (mul_sts.done) n_state = S_UPDATE;
            S_UPDATE:  n_state = n_need_dist ? S_DIST : S_SQR;
            S_DIST:    n_state = S_DIST_W;
            S_DIST_W:  if (mul_sts.done) n_state = S_SQR;
            S_SQR:     n_state = S_SQR_W;
            S_SQR_W: begin
                if (mul_sts.done) begin
                    n_state = (r_brake != '0) ? S_DIV : S_DONE;
                end
            end
            S_DIV:     n_state = S_DIV_W;
            S_DIV_W:   if (div_sts.done) n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        mul_ctl.start = 1'b0;
        div_ctl.start = 1'b0;
        mul_mcand     = {{(MCAND_W-RATE_W){1'b0}}, r_accel};
        mul_mplier    = {{(MPLR_W-RATE_W){1'b0}}, r_t};
        mul_steps     = STEPS_TIME;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_DELTA: begin
                mul_ctl.start = 1'b1;
                if (r_op == OP_DECEL) begin
                    mul_mcand = {{(MCAND_W-RATE_W){1'b0}}, r_brake};
                end
            end
            S_DIST: begin
                mul_ctl.start = 1'b1;
                mul_mcand     = r_sum;
            end
            S_SQR: begin
                mul_ctl.start = 1'b1;
                mul_mcand     = {1'b0, r_speed};
                mul_mplier    = r_speed;
                mul_steps     = STEPS_SPEED;
            end
            S_DIV:   div_ctl.start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= '0;
            r_accel     <= '0;
            r_brake     <= '0;
            r_speed     <= '0;
            r_mode      <= MODE_STOPPED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    CFG_ACCEL: r_accel <= i_cfg_data[RATE_W-1:0];
                    CFG_BRAKE: r_brake <= i_cfg_data[RATE_W-1:0];
                    default:   ;
                endcase
            end
            if (r_state == S_UPDATE) begin
                r_speed <= n_speed;
                r_mode  <= n_mode;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op <= i_opcode;
            r_t  <= i_time_step;
        end
        if (r_state == S_UPDATE) begin
            r_sum       <= {1'b0, r_speed} + {1'b0, n_speed};
            r_need_dist <= n_need_dist;
            r_dist      <= '0;
        end
        // 16-step product at [48:8], then >> 9
        if ((r_state == S_DIST_W) && mul_sts.done && r_need_dist) begin
            r_dist <= mul_prod[PROD_W-1:17];
        end
        if ((r_state == S_SQR_W) && mul_sts.done) begin
            r_bdist <= '0;
        end
        if ((r_state == S_DIV_W) && div_sts.done) begin
            if (div_quot[DVD_W-1:BDIST_W] != '0) begin
                r_bdist <= '1;
            end else begin
                r_bdist <= div_quot[BDIST_W-1:0];
            end
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_dist  <= r_dist;
            r_out_speed <= r_speed;
            r_out_mode  <= r_mode;
            r_out_bdist <= r_bdist;
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_distance         = r_out_dist;
    assign o_new_speed        = r_out_speed;
    assign o_motion_state     = r_out_mode;
    assign o_braking_distance = r_out_bdist;

endmodule
